// ----- hdl/pts_pkg.sv -----
// Shared types and constants for the priority task scheduler.
package pts_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);

    localparam int PRIO_W     = 7;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int NEST_W     = 8;
    localparam int TASK_ID_W  = 4;

    localparam logic [PRIO_W-1:0]  IDLE_PRIORITY = PRIO_W'(99);
    localparam logic [PRIO_W-1:0]  FREE_PRIORITY = PRIO_W'(100);
    localparam logic [SLOT_W-1:0]  IDLE_SLOT     = '0;
    localparam logic [SLOT_W-1:0]  FIRST_TASK    = SLOT_W'(1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT     = SLOT_W'(TASK_SLOTS - 1);
    localparam logic [NEST_W-1:0]  NEST_MAX      = '1;

    // Stream word widths; both tdata widths are padded to whole bytes.
    localparam int S_DATA_W = ((PRIO_W + DELAY_W + 7) / 8) * 8;
    localparam int S_USER_W = 3;
    localparam int M_FIELD_W = TASK_ID_W + 2 + 2 * COUNT_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        OP_CREATE    = 3'd0,
        OP_RUN       = 3'd1,
        OP_DELAY     = 3'd2,
        OP_TICK      = 3'd3,
        OP_ISR_ENTER = 3'd4,
        OP_ISR_EXIT  = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TICK  = 4'b0010,
        ST_SCHED = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

// ----- hdl/priority_task_scheduler.sv -----
// Fixed-priority preemptive task scheduler with delay ticks, top level.
//
//  channel | direction | tvalid/tready   | tdata / tuser contents (low bit up)
//  --------+-----------+-----------------+---------------------------------------------
//  s_axis  | in        | event word      | tuser: operation[2:0]
//          |           |                 | tdata: priority_req[6:0], delay_ticks[22:7], pad
//  m_axis  | out       | one result word | tdata: running_task[3:0], switched[4],
//          |           |   per event     |        rejected[5], switch_count[21:6],
//          |           |                 |        tick_count[37:22], pad
//
// Paths: ISR enter/exit without reschedule, ignored runs, unknown codes and a
// rejected create go straight to the result state; a tick walks slots
// 1..TASK_SLOTS-1 one per cycle; create, run, delay and the last ISR exit walk all
// slots through one shared priority comparator before the result state.
// Reset (aresetn low, synchronous) restores the idle task in slot 0 at once.
// The next event word is taken while a result still waits on m_axis; the block
// holds its finished result only if m_axis is still stalled with the previous one.
module priority_task_scheduler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // operation[2:0]
    input  logic [pts_pkg::S_USER_W-1:0] s_axis_tuser,
    // priority_req[6:0], delay_ticks[22:7], zero pad[23]
    input  logic [pts_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // running_task[3:0], switched[4], rejected[5], switch_count[21:6],
    // tick_count[37:22], zero pad[39:38]
    output logic [pts_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int N = pts_pkg::TASK_SLOTS;
    localparam int SW = pts_pkg::SLOT_W;

    // Task table
    logic [pts_pkg::PRIO_W-1:0]  prio_reg  [N];
    logic [pts_pkg::PRIO_W-1:0]  prio_next [N];
    logic [pts_pkg::DELAY_W-1:0] delay_reg [N];
    logic [pts_pkg::DELAY_W-1:0] delay_next[N];
    logic [N-1:0]                ready_reg, ready_next;
    logic [N-1:0]                used_reg, used_next;

    // Kernel state
    logic [SW-1:0]               cur_reg, cur_next;
    logic                        started_reg, started_next;
    logic                        created_reg, created_next;
    logic                        first_reg, first_next;
    logic [pts_pkg::NEST_W-1:0]  nest_reg, nest_next;
    logic [pts_pkg::COUNT_W-1:0] switches_reg, switches_next;
    logic [pts_pkg::COUNT_W-1:0] ticks_reg, ticks_next;

    // Sequencer
    pts_pkg::state_t             state_reg, state_next;
    logic [SW-1:0]               idx_reg, idx_next;
    logic [pts_pkg::PRIO_W-1:0]  best_reg, best_next;
    logic [SW-1:0]               pick_reg, pick_next;
    logic                        sw_reg, sw_next;
    logic                        rej_reg, rej_next;

    // Result word
    logic                        m_valid_reg, m_valid_next;
    logic [pts_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // Input fields
    pts_pkg::op_t                in_op;
    logic [pts_pkg::PRIO_W-1:0]  in_prio;
    logic [pts_pkg::DELAY_W-1:0] in_delay;
    logic                        s_accept;

    // First free slot
    logic [SW-1:0]               free_slot;
    logic                        free_found;

    // Shared comparator for the scan
    logic                        cand;
    logic [SW-1:0]               final_pick;

    assign in_op    = pts_pkg::op_t'(s_axis_tuser);
    assign in_prio  = s_axis_tdata[pts_pkg::PRIO_W-1:0];
    assign in_delay = s_axis_tdata[pts_pkg::PRIO_W +: pts_pkg::DELAY_W];

    assign s_axis_tready = (state_reg == pts_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Lowest unused slot, walking down so the lowest index wins.
    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int s = N - 1; s >= 0; s--) begin
            if (!used_reg[s]) begin
                free_slot  = SW'(s);
                free_found = 1'b1;
            end
        end
    end

    assign cand = used_reg[idx_reg] && ready_reg[idx_reg] && (prio_reg[idx_reg] < best_reg);
    assign final_pick = cand ? idx_reg : pick_reg;

    always_comb begin
        prio_next     = prio_reg;
        delay_next    = delay_reg;
        ready_next    = ready_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        started_next  = started_reg;
        created_next  = created_reg;
        first_next    = first_reg;
        nest_next     = nest_reg;
        switches_next = switches_reg;
        ticks_next    = ticks_reg;
        state_next    = state_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        sw_next       = sw_reg;
        rej_next      = rej_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            pts_pkg::ST_IDLE: begin
                if (s_accept) begin
                    sw_next    = 1'b0;
                    rej_next   = 1'b0;
                    idx_next   = '0;
                    best_next  = pts_pkg::FREE_PRIORITY;
                    pick_next  = pts_pkg::IDLE_SLOT;
                    state_next = pts_pkg::ST_DONE;
                    unique case (in_op)
                        pts_pkg::OP_CREATE: begin
                            if (free_found) begin
                                used_next[free_slot]  = 1'b1;
                                ready_next[free_slot] = 1'b1;
                                delay_next[free_slot] = '0;
                                prio_next[free_slot]  = in_prio;
                                created_next          = 1'b1;
                                state_next            = pts_pkg::ST_SCHED;
                            end else begin
                                rej_next = 1'b1;
                            end
                        end
                        pts_pkg::OP_RUN: begin
                            if (!started_reg && created_reg) begin
                                started_next = 1'b1;
                                state_next   = pts_pkg::ST_SCHED;
                            end
                        end
                        pts_pkg::OP_DELAY: begin
                            // Idle never sleeps; a zero delay keeps the task ready.
                            if (cur_reg != pts_pkg::IDLE_SLOT && in_delay != '0) begin
                                delay_next[cur_reg] = in_delay;
                                ready_next[cur_reg] = 1'b0;
                            end
                            state_next = pts_pkg::ST_SCHED;
                        end
                        pts_pkg::OP_TICK: begin
                            ticks_next = ticks_reg + 1'b1;
                            idx_next   = pts_pkg::FIRST_TASK;
                            state_next = pts_pkg::ST_TICK;
                        end
                        pts_pkg::OP_ISR_ENTER: begin
                            if (nest_reg != pts_pkg::NEST_MAX) begin
                                nest_next = nest_reg + 1'b1;
                            end
                        end
                        pts_pkg::OP_ISR_EXIT: begin
                            if (nest_reg != '0) begin
                                nest_next = nest_reg - 1'b1;
                                if (nest_next == '0 && started_reg && created_reg) begin
                                    state_next = pts_pkg::ST_SCHED;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            pts_pkg::ST_TICK: begin
                // Count down one sleeping task per cycle; wake it at one or zero.
                if (used_reg[idx_reg] && !ready_reg[idx_reg]) begin
                    if (delay_reg[idx_reg] <= pts_pkg::DELAY_W'(1)) begin
                        ready_next[idx_reg] = 1'b1;
                        delay_next[idx_reg] = '0;
                    end else begin
                        delay_next[idx_reg] = delay_reg[idx_reg] - 1'b1;
                    end
                end
                if (idx_reg == pts_pkg::LAST_SLOT) begin
                    state_next = pts_pkg::ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            pts_pkg::ST_SCHED: begin
                if (cand) begin
                    best_next = prio_reg[idx_reg];
                    pick_next = idx_reg;
                end
                if (idx_reg == pts_pkg::LAST_SLOT) begin
                    state_next = pts_pkg::ST_DONE;
                    if (started_reg) begin
                        if (first_reg) begin
                            first_next = 1'b0;
                            cur_next   = final_pick;
                            sw_next    = 1'b1;
                        end else if (final_pick != cur_reg) begin
                            switches_next = switches_reg + 1'b1;
                            cur_next      = final_pick;
                            sw_next       = 1'b1;
                        end
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            pts_pkg::ST_DONE: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pts_pkg::M_DATA_W'({ticks_reg, switches_reg, rej_reg,
                                                       sw_reg,
                                                       pts_pkg::TASK_ID_W'(cur_reg)});
                    state_next   = pts_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < N; s++) begin
                prio_reg[s]  <= (s == 0) ? pts_pkg::IDLE_PRIORITY : pts_pkg::FREE_PRIORITY;
                delay_reg[s] <= '0;
            end
            ready_reg    <= N'(1);
            used_reg     <= N'(1);
            cur_reg      <= pts_pkg::IDLE_SLOT;
            started_reg  <= 1'b0;
            created_reg  <= 1'b0;
            first_reg    <= 1'b1;
            nest_reg     <= '0;
            switches_reg <= '0;
            ticks_reg    <= '0;
            state_reg    <= pts_pkg::ST_IDLE;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            prio_reg     <= prio_next;
            delay_reg    <= delay_next;
            ready_reg    <= ready_next;
            used_reg     <= used_next;
            cur_reg      <= cur_next;
            started_reg  <= started_next;
            created_reg  <= created_next;
            first_reg    <= first_next;
            nest_reg     <= nest_next;
            switches_reg <= switches_next;
            ticks_reg    <= ticks_next;
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        sw_reg     <= sw_next;
        rej_reg    <= rej_next;
        m_data_reg <= m_data_next;
    end

    // The idle task stays in its slot and stays ready.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg[0] && ready_reg[0])
        else $error("idle task lost its slot or readiness");

    // The running task always names a created slot.
    a_cur_used: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg[cur_reg])
        else $error("running task points at a free slot");

    // The switch counter moves only at the end of a scheduling scan.
    a_switch_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pts_pkg::ST_SCHED) |=> $stable(switches_reg))
        else $error("switch count changed outside scheduling");

    // A rejected create never dispatches.
    a_rej_no_sw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[pts_pkg::TASK_ID_W] && m_data_reg[pts_pkg::TASK_ID_W + 1]))
        else $error("result both rejected and switched");

endmodule

// ----- tb/sched_checker.sv -----
// Event predictor and result comparator for the priority task scheduler.
module sched_checker
    import pts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_USER_W-1:0] s_axis_tuser,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    output int                  fail_count,
    output int                  pending_count
);

    typedef struct {
        logic [TASK_ID_W-1:0] running;
        logic                 switched;
        logic                 rejected;
        logic [COUNT_W-1:0]   switch_total;
        logic [COUNT_W-1:0]   tick_total;
    } sched_result_t;

    sched_result_t due_results[$];
    sched_result_t oldest;
    int            fails = 0;

    logic [PRIO_W-1:0]  prio_tbl  [TASK_SLOTS];
    logic               ready_tbl [TASK_SLOTS];
    logic               used_tbl  [TASK_SLOTS];
    logic [DELAY_W-1:0] sleep_tbl [TASK_SLOTS];
    int unsigned        cur_slot;
    logic               started;
    logic               any_created;
    logic               first_pending;
    logic [NEST_W-1:0]  nest_depth;
    logic [COUNT_W-1:0] switch_total;
    logic [COUNT_W-1:0] tick_total;

    function automatic void clear_table();
        for (int s = 0; s < TASK_SLOTS; s++) begin
            prio_tbl[s]  = FREE_PRIORITY;
            ready_tbl[s] = 1'b0;
            used_tbl[s]  = 1'b0;
            sleep_tbl[s] = '0;
        end
        prio_tbl[0]   = IDLE_PRIORITY;
        ready_tbl[0]  = 1'b1;
        used_tbl[0]   = 1'b1;
        cur_slot      = 0;
        started       = 1'b0;
        any_created   = 1'b0;
        first_pending = 1'b1;
        nest_depth    = '0;
        switch_total  = '0;
        tick_total    = '0;
    endfunction

    // Pick the most urgent ready slot; return 1 on a dispatch.
    function automatic logic dispatch_best();
        int unsigned best_prio;
        int unsigned pick;
        best_prio = FREE_PRIORITY;
        pick      = 0;
        if (!started)
            return 1'b0;
        for (int s = 0; s < TASK_SLOTS; s++) begin
            if (used_tbl[s] && ready_tbl[s] && prio_tbl[s] < best_prio) begin
                best_prio = prio_tbl[s];
                pick      = s;
            end
        end
        if (first_pending) begin
            first_pending = 1'b0;
            cur_slot      = pick;
            return 1'b1;
        end
        if (pick == cur_slot)
            return 1'b0;
        switch_total = switch_total + 1'b1;
        cur_slot     = pick;
        return 1'b1;
    endfunction

    function automatic sched_result_t apply_event(logic [S_USER_W-1:0] op,
                                                  logic [PRIO_W-1:0] prio,
                                                  logic [DELAY_W-1:0] sleep_req);
        sched_result_t res;
        int            free_slot;
        res.switched = 1'b0;
        res.rejected = 1'b0;
        free_slot    = TASK_SLOTS;
        case (op)
            OP_CREATE: begin
                for (int s = TASK_SLOTS - 1; s >= 0; s--)
                    if (!used_tbl[s])
                        free_slot = s;
                if (free_slot == TASK_SLOTS) begin
                    res.rejected = 1'b1;
                end else begin
                    used_tbl[free_slot]  = 1'b1;
                    ready_tbl[free_slot] = 1'b1;
                    sleep_tbl[free_slot] = '0;
                    prio_tbl[free_slot]  = prio;
                    any_created          = 1'b1;
                    res.switched         = dispatch_best();
                end
            end
            OP_RUN: begin
                if (!started && any_created) begin
                    started      = 1'b1;
                    res.switched = dispatch_best();
                end
            end
            OP_DELAY: begin
                // idle and a zero count both leave the running task ready
                if (cur_slot != 0 && sleep_req != 0) begin
                    sleep_tbl[cur_slot] = sleep_req;
                    ready_tbl[cur_slot] = 1'b0;
                end
                res.switched = dispatch_best();
            end
            OP_TICK: begin
                tick_total = tick_total + 1'b1;
                for (int s = 1; s < TASK_SLOTS; s++) begin
                    if (used_tbl[s] && !ready_tbl[s]) begin
                        if (sleep_tbl[s] <= 1) begin
                            ready_tbl[s] = 1'b1;
                            sleep_tbl[s] = '0;
                        end else begin
                            sleep_tbl[s] = sleep_tbl[s] - 1'b1;
                        end
                    end
                end
            end
            OP_ISR_ENTER: begin
                if (nest_depth != NEST_MAX)
                    nest_depth = nest_depth + 1'b1;
            end
            OP_ISR_EXIT: begin
                if (nest_depth != 0) begin
                    nest_depth = nest_depth - 1'b1;
                    if (nest_depth == 0 && started && any_created)
                        res.switched = dispatch_best();
                end
            end
            default: ;
        endcase
        res.running      = cur_slot[TASK_ID_W-1:0];
        res.switch_total = switch_total;
        res.tick_total   = tick_total;
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_table();
            due_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(apply_event(s_axis_tuser,
                                                  s_axis_tdata[PRIO_W-1:0],
                                                  s_axis_tdata[PRIO_W +: DELAY_W]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $error("result word 0x%0h with no event waiting", m_axis_tdata);
                    fails++;
                end else begin
                    oldest = due_results.pop_front();
                    check_field("running_task", oldest.running,
                                m_axis_tdata[TASK_ID_W-1:0]);
                    check_field("switched", oldest.switched, m_axis_tdata[TASK_ID_W]);
                    check_field("rejected", oldest.rejected, m_axis_tdata[TASK_ID_W+1]);
                    check_field("switch_count", oldest.switch_total,
                                m_axis_tdata[TASK_ID_W+2 +: COUNT_W]);
                    check_field("tick_count", oldest.tick_total,
                                m_axis_tdata[TASK_ID_W+2+COUNT_W +: COUNT_W]);
                end
            end
        end
        fail_count    <= fails;
        pending_count <= due_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Top testbench for the priority task scheduler: stimulus, stalls and verdict.
module tb;
    import pts_pkg::*;

    // Codes outside the defined operations; the block must report its state unchanged.
    localparam logic [S_USER_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [S_USER_W-1:0] OP_UNDEF_HI = 3'd7;

    localparam int RANDOM_EVENTS = 100;
    localparam int NEST_BURST    = 258;   // enough ISR enters to saturate the depth
    localparam int NEST_UNWIND   = 3;     // exits taken back from the saturated depth
    localparam int LONG_HOLD     = 500;   // receiver stall that backs the block up
    localparam int HOLD_AFTER    = 60;    // results to pass before that stall
    localparam int DRAIN_CYCLES  = 60;    // settle time after the last result
    localparam int IDLE_LIMIT    = 4000;  // watchdog: cycles with no word moving

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_USER_W-1:0] s_axis_tuser  = '0;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    int          fail_count;
    int          pending_count;
    int unsigned events_sent = 0;
    int unsigned cycle_no    = 0;

    priority_task_scheduler uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),   // operation[2:0]
        .s_axis_tdata  (s_axis_tdata),   // priority_req[6:0], delay_ticks[22:7], pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // running_task, switched, rejected, counts
    );

    sched_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk)
        cycle_no <= cycle_no + 1;

    // Sender gap: mostly back to back or short, now and then long; every third
    // stretch of fifty events goes out without gaps at all.
    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((events_sent / 50) % 3 == 1)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one event word and hold it until the block takes it.
    task automatic send_event(input logic [S_USER_W-1:0] op,
                              input logic [PRIO_W-1:0]   prio,
                              input logic [DELAY_W-1:0]  sleep_req);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= S_DATA_W'({sleep_req, prio});
        do @(posedge aclk); while (!s_axis_tready);
        events_sent++;
    endtask

    function automatic logic [PRIO_W-1:0] random_prio();
        if ($urandom_range(0, 99) < 85)
            return PRIO_W'($urandom_range(0, 99));
        return PRIO_W'($urandom_range(100, 127));
    endfunction

    // Keep most sleeps short so tasks wake again; a few reach far out.
    function automatic logic [DELAY_W-1:0] random_sleep();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 88)
            return DELAY_W'($urandom_range(1, 6));
        if (r < 97)
            return DELAY_W'($urandom_range(7, 40));
        return DELAY_W'($urandom_range(0, 65535));
    endfunction

    // Receiver: random stalls, one long hold once traffic is flowing, and
    // calm stretches with tready held high.
    initial begin
        int unsigned hold;
        int unsigned taken;
        int unsigned r;
        bit          long_done;
        hold      = 0;
        taken     = 0;
        long_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                taken++;
            if (!long_done && taken >= HOLD_AFTER) begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
            end
            r = $urandom_range(0, 99);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if ((cycle_no / 700) % 3 == 2 || r < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned r;
        logic [S_USER_W-1:0] op;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: events before start, ignored codes, first dispatch,
        // zero and idle sleeps, nested ISR wake-up, priority ties and extremes.
        send_event(OP_TICK,      7'd0,   16'd0);
        send_event(OP_ISR_EXIT,  7'd0,   16'd0);       // exit at depth zero
        send_event(OP_DELAY,     7'd0,   16'h8000);    // before start: lands on idle
        send_event(OP_RUN,       7'd0,   16'd0);       // nothing created yet
        send_event(OP_UNDEF_LO,  7'h55,  16'hAAAA);
        send_event(OP_UNDEF_HI,  7'h2A,  16'h5555);
        send_event(OP_CREATE,    7'd127, 16'd0);       // never eligible
        send_event(OP_CREATE,    7'd0,   16'd0);
        send_event(OP_RUN,       7'd0,   16'd0);       // first dispatch
        send_event(OP_RUN,       7'd0,   16'd0);       // second run is ignored
        send_event(OP_DELAY,     7'd0,   16'd0);       // zero sleep keeps it ready
        send_event(OP_DELAY,     7'd0,   16'd3);
        send_event(OP_DELAY,     7'd0,   16'd5);       // aimed at idle
        send_event(OP_ISR_ENTER, 7'd0,   16'd0);
        send_event(OP_ISR_ENTER, 7'd0,   16'd0);
        send_event(OP_TICK,      7'd0,   16'd0);
        send_event(OP_ISR_EXIT,  7'd0,   16'd0);
        send_event(OP_TICK,      7'd0,   16'd0);
        send_event(OP_TICK,      7'd0,   16'd0);       // sleeper wakes here
        send_event(OP_ISR_EXIT,  7'd0,   16'd0);       // outermost exit reschedules
        send_event(OP_CREATE,    7'd99,  16'd0);       // ties with idle
        send_event(OP_CREATE,    7'd100, 16'd0);       // free-marker priority
        send_event(OP_DELAY,     7'd0,   16'hFFFF);

        // Pause until every result so far has come back.
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);

        // Random kernel traffic: a few creates mixed into mostly sleeps,
        // ticks and shallow ISR nesting.
        for (int i = 0; i < RANDOM_EVENTS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                op = OP_CREATE;
            else if (r < 10)
                op = OP_RUN;
            else if (r < 40)
                op = OP_DELAY;
            else if (r < 74)
                op = OP_TICK;
            else if (r < 85)
                op = OP_ISR_ENTER;
            else if (r < 97)
                op = OP_ISR_EXIT;
            else
                op = (r < 99) ? OP_UNDEF_LO : OP_UNDEF_HI;
            send_event(op, random_prio(), random_sleep());
        end

        // Fill the table; at least the last create is turned away.
        for (int i = 0; i < TASK_SLOTS; i++)
            send_event(OP_CREATE, random_prio(), random_sleep());

        // Drive the nesting depth into saturation, then step back a little.
        for (int i = 0; i < NEST_BURST; i++)
            send_event(OP_ISR_ENTER, random_prio(), random_sleep());
        for (int i = 0; i < NEST_UNWIND; i++)
            send_event(OP_ISR_EXIT, random_prio(), random_sleep());

        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pts_pkg.sv
hdl/priority_task_scheduler.sv
tb/sched_checker.sv
tb/tb.sv
